// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file pool3_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also applies during reset.
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/pool3_pkg.sv -----
// Shared types and constants for the 3x3 int8 pooling block.
package pool3_pkg;

  localparam int PIX_W         = 8;
  localparam int LANES         = 4;
  localparam int WORD_W        = PIX_W * LANES;
  localparam int PART_W        = 11;   // column partial: sum of three int8
  localparam int SUM_W         = 12;   // window: sum of nine int8
  localparam int ROW_W         = 12;
  localparam int ROW_LIMIT     = 4095;
  localparam int CFG_DIM_W     = 11;
  localparam int MIN_WIDTH     = 3;
  localparam int WIN_EDGE      = 2;    // window size minus one
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam logic [1:0]       STRIDE_TWO = 2'd2;
  localparam logic [PIX_W-1:0] PAD_MAX    = 8'h80;
  localparam logic [PIX_W-1:0] PAD_AVG    = 8'h00;

  typedef enum logic [2:0] {
    REG_POOL_MODE     = 3'd0,
    REG_WINDOW_STRIDE = 3'd1,
    REG_PADDED_WIDTH  = 3'd2,
    REG_OUT_HEIGHT    = 3'd3,
    REG_OUT_WIDTH     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                 pool_mode;
    logic [1:0]           window_stride;
    logic [CFG_DIM_W-1:0] padded_width;
    logic [CFG_DIM_W-1:0] out_height;
    logic [CFG_DIM_W-1:0] out_width;
  } cfg_t;

  // Window placement of one beat.
  typedef struct packed {
    logic emit;
    logic last;
  } pos_t;

endpackage

// ----- rtl/core/pool3_rowbuf.sv -----
// Two line stores (upper and middle row) with registered read and write forwarding.
module pool3_rowbuf #(
  parameter int MAX_WIDTH = pool3_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [pool3_pkg::WORD_W-1:0] wr_up,
  input  logic [pool3_pkg::WORD_W-1:0] wr_mid,
  output logic [pool3_pkg::WORD_W-1:0] rd_up,
  output logic [pool3_pkg::WORD_W-1:0] rd_mid
);

  logic [pool3_pkg::WORD_W-1:0] upper_mem [MAX_WIDTH];
  logic [pool3_pkg::WORD_W-1:0] middle_mem [MAX_WIDTH];

  logic [pool3_pkg::WORD_W-1:0] up_q_r, mid_q_r;
  logic [pool3_pkg::WORD_W-1:0] fwd_up_r, fwd_mid_r;
  logic                         fwd_r;
  logic                         fwd_nxt;

  // same-edge write to the address being read: memory returns old data
  assign fwd_nxt = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_up;
      middle_mem[wr_addr] <= wr_mid;
    end
    if (rd_en) begin
      up_q_r    <= upper_mem[rd_addr];
      mid_q_r   <= middle_mem[rd_addr];
      fwd_up_r  <= wr_up;
      fwd_mid_r <= wr_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= fwd_nxt;
    end
  end

  assign rd_up  = fwd_r ? fwd_up_r  : up_q_r;
  assign rd_mid = fwd_r ? fwd_mid_r : mid_q_r;

endmodule

// ----- rtl/core/pool3_ctrl.sv -----
// Row/column counters and window placement for the incoming beat.
module pool3_ctrl #(
  parameter int MAX_WIDTH = pool3_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         frame_start,
  input  pool3_pkg::cfg_t              cfg,
  output logic [$clog2(MAX_WIDTH)-1:0] col_addr,
  output pool3_pkg::pos_t              pos
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > pool3_pkg::CFG_DIM_W) ? CW : pool3_pkg::CFG_DIM_W;
  localparam int RW = pool3_pkg::ROW_W;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic [WW-1:0] pw, width_ww;
  logic [CW-1:0] width_c;
  logic [RW-1:0] row0, row1, dr, dr_q, oh;
  logic [CW-1:0] col0, col1, col2, dc, dc_q;
  logic [WW-1:0] dcq_w, ow;
  logic          wrap0, wrap1, stride2, dr_al, dc_al, ok_r, ok_c;

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    row_inc = (r == RW'(pool3_pkg::ROW_LIMIT)) ? r : r + RW'(1);
  endfunction

  always_comb begin
    pw       = WW'(cfg.padded_width);
    width_ww = pw;
    if (pw < WW'(pool3_pkg::MIN_WIDTH)) begin
      width_ww = WW'(pool3_pkg::MIN_WIDTH);
    end else if (pw > WW'(MAX_WIDTH)) begin
      width_ww = WW'(MAX_WIDTH);
    end
    width_c = width_ww[CW-1:0];

    row0  = frame_start ? '0 : row_r;
    col0  = frame_start ? '0 : col_r;
    wrap0 = (col0 >= width_c);
    col1  = wrap0 ? '0 : col0;
    row1  = wrap0 ? row_inc(row0) : row0;
    col2  = col1 + CW'(1);
    wrap1 = (col2 >= width_c);

    col_nxt = wrap1 ? '0 : col2;
    row_nxt = wrap1 ? row_inc(row1) : row1;

    stride2 = (cfg.window_stride == pool3_pkg::STRIDE_TWO);
    ok_r    = (row1 >= RW'(pool3_pkg::WIN_EDGE));
    ok_c    = (col1 >= CW'(pool3_pkg::WIN_EDGE));
    dr      = row1 - RW'(pool3_pkg::WIN_EDGE);
    dc      = col1 - CW'(pool3_pkg::WIN_EDGE);
    dr_q    = stride2 ? (dr >> 1) : dr;
    dc_q    = stride2 ? (dc >> 1) : dc;
    dr_al   = !stride2 || !dr[0];
    dc_al   = !stride2 || !dc[0];
    oh      = RW'(cfg.out_height);
    ow      = WW'(cfg.out_width);
    dcq_w   = WW'(dc_q);

    pos.emit = ok_r && ok_c && dr_al && dc_al && (dr_q < oh) && (dcq_w < ow);
    pos.last = (dr_q == oh - RW'(1)) && (dcq_w == ow - WW'(1));
    col_addr = col1[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ----- rtl/core/pool3_lane.sv -----
// One channel lane: vertical merge, column partials, window merge and, in average mode, divide by nine.
module pool3_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               clr,
  input  logic                               avg,
  input  logic signed [pool3_pkg::PIX_W-1:0] up,
  input  logic signed [pool3_pkg::PIX_W-1:0] mid,
  input  logic signed [pool3_pkg::PIX_W-1:0] cur,
  output logic signed [pool3_pkg::PIX_W-1:0] res
);

  localparam int SW       = pool3_pkg::SUM_W;
  localparam int PW       = pool3_pkg::PART_W;
  localparam int MAG_W    = SW - 1;
  localparam int DIV_SH   = 14;
  localparam int DIV_MUL  = (1 << DIV_SH) / 9 + 1;   // ceil(2^14 / 9)
  localparam int HALF     = 9 / 2;
  localparam int PROD_W   = 2 * MAG_W;

  logic signed [PW-1:0]      p0_r, p1_r, q0, q1;
  logic signed [SW-1:0]      now, win, mag;
  logic [MAG_W-1:0]          plus;
  logic [PROD_W-1:0]         prod;
  logic [pool3_pkg::PIX_W-1:0] quo, quot;

  function automatic logic signed [SW-1:0] merge3(
    input logic signed [SW-1:0] a,
    input logic signed [SW-1:0] b,
    input logic signed [SW-1:0] c,
    input logic                 sum
  );
    logic signed [SW-1:0] m;
    m = (a > b) ? a : b;
    m = (m > c) ? m : c;
    merge3 = sum ? (a + b + c) : m;
  endfunction

  always_comb begin
    now  = merge3(SW'(up), SW'(mid), SW'(cur), avg);
    q0   = clr ? '0 : p0_r;
    q1   = clr ? '0 : p1_r;
    win  = merge3(SW'(q0), SW'(q1), now, avg);
    // round half away from zero: (|s| + 4) / 9 by reciprocal, then restore sign
    mag  = win[SW-1] ? -win : win;
    plus = mag[MAG_W-1:0] + MAG_W'(HALF);
    prod = PROD_W'(plus) * PROD_W'(DIV_MUL);
    quo  = prod[DIV_SH +: pool3_pkg::PIX_W];
    quot = win[SW-1] ? -quo : quo;
    res  = avg ? $signed(quot) : win[pool3_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r <= '0;
      p1_r <= '0;
    end else if (adv) begin
      p0_r <= q1;
      p1_r <= now[PW-1:0];
    end
  end

endmodule

// ----- rtl/core/int8_pool3x3_four_channel.sv -----
// Top level: 3x3 max/average pooling over a padded four-channel int8 pixel stream.
//
//  Channel   Dir  Handshake            Beat contents
//  in_*      in   in_valid / in_stall  four int8 channels, pad mark, frame start
//  out_*     out  out_valid / out_stall four pooled int8 channels, frame last
//  cfg (APB) in   psel/penable/pwrite  pool mode, stride, widths, output size
//
//  One pixel per cycle while in_stall is low; an input beat passes the line store
//  read into stage 1, then the lane merge into the output register.
//  Two 1-port-write/1-port-read line stores of MAX_WIDTH words hold the rows above.
//  rst_n is synchronous; it clears counters, column partials and valids.
//  Line stores are not cleared: every entry is written by row 0 and 1 of a frame
//  before a window reads it.
//  Input stalls only when stage 1 holds a window result and the output
//  register is full and stalled.
module int8_pool3x3_four_channel #(
  parameter int MAX_WIDTH = pool3_pkg::DEF_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pool3_pkg::PIX_W-1:0]  in_pixel_ch0,
  input  logic signed [pool3_pkg::PIX_W-1:0]  in_pixel_ch1,
  input  logic signed [pool3_pkg::PIX_W-1:0]  in_pixel_ch2,
  input  logic signed [pool3_pkg::PIX_W-1:0]  in_pixel_ch3,
  input  logic                                in_is_pad,
  input  logic                                in_frame_start,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pool3_pkg::PIX_W-1:0]  out_result_ch0,
  output logic signed [pool3_pkg::PIX_W-1:0]  out_result_ch1,
  output logic signed [pool3_pkg::PIX_W-1:0]  out_result_ch2,
  output logic signed [pool3_pkg::PIX_W-1:0]  out_result_ch3,
  output logic                                out_frame_last,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pool3_pkg::ADDR_W-1:0]        paddr,
  input  logic [pool3_pkg::DATA_W-1:0]        pwdata,
  output logic [pool3_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int PXW = pool3_pkg::PIX_W;
  localparam int NL  = pool3_pkg::LANES;
  localparam int DW  = pool3_pkg::DATA_W;
  localparam int CDW = pool3_pkg::CFG_DIM_W;

  // ---------------- configuration registers ----------------
  pool3_pkg::cfg_t     cfg_r;
  pool3_pkg::reg_idx_t reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = pool3_pkg::reg_idx_t'(paddr[pool3_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pool_mode     <= 1'b0;
      cfg_r.window_stride <= 2'd1;
      cfg_r.padded_width  <= CDW'(pool3_pkg::MIN_WIDTH);
      cfg_r.out_height    <= CDW'(1);
      cfg_r.out_width     <= CDW'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pool3_pkg::REG_POOL_MODE:     cfg_r.pool_mode     <= pwdata[0];
        pool3_pkg::REG_WINDOW_STRIDE: cfg_r.window_stride <= pwdata[1:0];
        pool3_pkg::REG_PADDED_WIDTH:  cfg_r.padded_width  <= pwdata[CDW-1:0];
        pool3_pkg::REG_OUT_HEIGHT:    cfg_r.out_height    <= pwdata[CDW-1:0];
        pool3_pkg::REG_OUT_WIDTH:     cfg_r.out_width     <= pwdata[CDW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pool3_pkg::REG_POOL_MODE:     prdata = DW'(cfg_r.pool_mode);
      pool3_pkg::REG_WINDOW_STRIDE: prdata = DW'(cfg_r.window_stride);
      pool3_pkg::REG_PADDED_WIDTH:  prdata = DW'(cfg_r.padded_width);
      pool3_pkg::REG_OUT_HEIGHT:    prdata = DW'(cfg_r.out_height);
      pool3_pkg::REG_OUT_WIDTH:     prdata = DW'(cfg_r.out_width);
      default:                      prdata = '0;
    endcase
  end

  // ---------------- stage 0: accept, count, pad, read line stores ----------------
  logic                         accept;
  logic [AW-1:0]                col_addr;
  pool3_pkg::pos_t              pos;
  logic [PXW-1:0]               pix [NL];
  logic [pool3_pkg::WORD_W-1:0] word;

  assign accept = in_valid && !in_stall;

  assign pix[0] = in_pixel_ch0;
  assign pix[1] = in_pixel_ch1;
  assign pix[2] = in_pixel_ch2;
  assign pix[3] = in_pixel_ch3;

  // pad value follows the mode in force when the pixel arrives
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      word[i*PXW +: PXW] = in_is_pad ?
        (cfg_r.pool_mode ? pool3_pkg::PAD_AVG : pool3_pkg::PAD_MAX) : pix[i];
    end
  end

  pool3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_frame_start),
    .cfg         (cfg_r),
    .col_addr    (col_addr),
    .pos         (pos)
  );

  // ---------------- stage 1: lanes ----------------
  logic                         s1_valid_r;
  logic [pool3_pkg::WORD_W-1:0] s1_word_r;
  logic [AW-1:0]                s1_addr_r;
  pool3_pkg::pos_t              s1_pos_r;
  logic                         s1_fs_r;
  logic                         s1_adv, out_free, out_load;
  logic [pool3_pkg::WORD_W-1:0] rd_up, rd_mid;
  logic signed [PXW-1:0]        lane_res [NL];

  assign out_free = !out_valid || !out_stall;
  // a beat with no window result leaves stage 1 even while the output is stalled
  assign s1_adv   = s1_valid_r && (!s1_pos_r.emit || out_free);
  assign out_load = s1_adv && s1_pos_r.emit;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= word;
      s1_addr_r <= col_addr;
      s1_pos_r  <= pos;
      s1_fs_r   <= in_frame_start;
    end
  end

  // upper row takes what was the middle row; middle takes the new pixel
  pool3_rowbuf #(.MAX_WIDTH(MAX_WIDTH)) u_rowbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col_addr),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_up   (rd_mid),
    .wr_mid  (s1_word_r),
    .rd_up   (rd_up),
    .rd_mid  (rd_mid)
  );

  for (genvar g = 0; g < NL; g++) begin : g_lane
    pool3_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (s1_adv),
      .clr   (s1_fs_r),
      .avg   (cfg_r.pool_mode),
      .up    ($signed(rd_up[g*PXW +: PXW])),
      .mid   ($signed(rd_mid[g*PXW +: PXW])),
      .cur   ($signed(s1_word_r[g*PXW +: PXW])),
      .res   (lane_res[g])
    );
  end

  // ---------------- stage 2: merge lanes into the output register ----------------
  logic                  out_valid_r;
  logic signed [PXW-1:0] res_r [NL];
  logic                  last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < NL; i++) begin
        res_r[i] <= lane_res[i];
      end
      last_r <= s1_pos_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_ch0 = res_r[0];
  assign out_result_ch1 = res_r[1];
  assign out_result_ch2 = res_r[2];
  assign out_result_ch3 = res_r[3];
  assign out_frame_last = last_r;

endmodule

// ----- rtl/core/pool3_chk.sv -----
// Port-level checker for the pooling block, bound to the top level.
`include "assert_macros.svh"

module pool3_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [pool3_pkg::PIX_W-1:0]  out_result_ch0,
  input logic signed [pool3_pkg::PIX_W-1:0]  out_result_ch1,
  input logic signed [pool3_pkg::PIX_W-1:0]  out_result_ch2,
  input logic signed [pool3_pkg::PIX_W-1:0]  out_result_ch3,
  input logic                                out_frame_last
);

  // input backpressure only comes from a full, stalled output register
  `CHK_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall), "in_stall without stalled output")

  // reset empties the output register
  `CHK_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid, "out_valid after reset")

  // a stalled output beat stays
  `CHK_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "out beat dropped")

  // and its payload holds
  `CHK_ASSERT(a_out_stable, clk, rst_n, (out_valid && out_stall) |=> ($stable(out_result_ch0) && $stable(out_result_ch1) && $stable(out_result_ch2) && $stable(out_result_ch3) && $stable(out_frame_last)), "out payload changed")

endmodule

bind int8_pool3x3_four_channel pool3_chk u_pool3_chk (.*);

// ----- tb/tb_int8_pool3x3_four_channel.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the 3x3 int8 max/avg pooling block.
module tb_int8_pool3x3_four_channel;

  localparam int PIX_W        = pool3_pkg::PIX_W;
  localparam int LANES        = pool3_pkg::LANES;
  localparam int CFG_DIM_W    = pool3_pkg::CFG_DIM_W;
  localparam int ADDR_W       = pool3_pkg::ADDR_W;
  localparam int DATA_W       = pool3_pkg::DATA_W;
  localparam int MIN_WIDTH    = pool3_pkg::MIN_WIDTH;
  localparam int WIN_EDGE     = pool3_pkg::WIN_EDGE;
  localparam int ROW_LIMIT    = pool3_pkg::ROW_LIMIT;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LINE_DEPTH   = pool3_pkg::DEF_MAX_WIDTH;
  localparam int DRAIN_CYCLES = 4;     // pipeline is two deep, plus margin
  localparam int WINDOW_CELLS = 9;
  localparam int RAND_ITEMS   = 700;
  localparam int DIR_ROWS     = 19;
  localparam int DIR_MAX_END  = 10;    // table rows below this run in max mode

  typedef logic [LANES-1:0][PIX_W-1:0] quad_t;

  typedef struct packed {
    quad_t ch;
    logic  last;
  } pooled_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    quad_t   ch;
    logic    pad;
    logic    fs;
    logic    typed;
    pooled_t want;
  } pixel_row_t;

  typedef enum {FR_WHOLE, FR_CONTINUE, FR_BROKEN, FR_MODE_FLIP} frame_kind_t;
  typedef enum {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic signed [PIX_W-1:0] in_pixel_ch0   = '0;
  logic signed [PIX_W-1:0] in_pixel_ch1   = '0;
  logic signed [PIX_W-1:0] in_pixel_ch2   = '0;
  logic signed [PIX_W-1:0] in_pixel_ch3   = '0;
  logic                    in_is_pad      = 1'b0;
  logic                    in_frame_start = 1'b0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic signed [PIX_W-1:0] out_result_ch0;
  logic signed [PIX_W-1:0] out_result_ch1;
  logic signed [PIX_W-1:0] out_result_ch2;
  logic signed [PIX_W-1:0] out_result_ch3;
  logic                    out_frame_last;
  logic                    psel           = 1'b0;
  logic                    penable        = 1'b0;
  logic                    pwrite         = 1'b0;
  logic [ADDR_W-1:0]       paddr          = '0;
  logic [DATA_W-1:0]       pwdata         = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  int8_pool3x3_four_channel DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_ch0   (in_pixel_ch0),
    .in_pixel_ch1   (in_pixel_ch1),
    .in_pixel_ch2   (in_pixel_ch2),
    .in_pixel_ch3   (in_pixel_ch3),
    .in_is_pad      (in_is_pad),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_ch0 (out_result_ch0),
    .out_result_ch1 (out_result_ch1),
    .out_result_ch2 (out_result_ch2),
    .out_result_ch3 (out_result_ch3),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // ---------------------------------------------------------------------------
  // Pooling predictor: its own copy of the registers, line stores and partials
  // ---------------------------------------------------------------------------
  logic                 cfg_mode;
  logic [1:0]           cfg_stride;
  logic [CFG_DIM_W-1:0] cfg_pwidth;
  logic [CFG_DIM_W-1:0] cfg_oh;
  logic [CFG_DIM_W-1:0] cfg_ow;

  quad_t       upper_line  [LINE_DEPTH];
  quad_t       middle_line [LINE_DEPTH];
  int          col_fold    [2][LANES];   // vertical max or sum of the last two columns
  int unsigned row_pos;
  int unsigned col_pos;

  pooled_t pending_pool [$];             // expected result beats, oldest first
  int      mismatches;
  int      beats_seen;
  int      cycles;
  int      send_gap_pct;
  int      stall_pct;

  function automatic int lane_merge(input int a, input int b, input int c, input logic avg);
    int m;
    if (avg) return a + b + c;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Advances the predictor by one pixel; returns 1 when a window completes.
  function automatic bit pool_step(input quad_t px, input logic pad, input logic fs,
                                   output pooled_t res);
    int unsigned step;
    int unsigned width;
    int unsigned col;
    int unsigned dr;
    int unsigned dc;
    quad_t       word;
    int          now_v [LANES];
    int          acc;
    int          i;
    bit          hit;
    step  = (cfg_stride == pool3_pkg::STRIDE_TWO) ? 2 : 1;
    width = (cfg_pwidth < MIN_WIDTH) ? MIN_WIDTH : cfg_pwidth;
    if (width > LINE_DEPTH) width = LINE_DEPTH;
    hit = 1'b0;
    res = '0;
    if (fs) begin
      row_pos  = 0;
      col_pos  = 0;
      col_fold = '{default: 0};
    end
    if (col_pos >= width) begin
      col_pos = 0;
      if (row_pos < ROW_LIMIT) row_pos++;
    end
    col = col_pos % LINE_DEPTH;
    // pad value follows the mode in force when the pixel arrives
    word = pad ? {LANES{cfg_mode ? pool3_pkg::PAD_AVG : pool3_pkg::PAD_MAX}} : px;
    for (i = 0; i < LANES; i++)
      now_v[i] = lane_merge($signed(upper_line[col][i]), $signed(middle_line[col][i]),
                            $signed(word[i]), cfg_mode);
    if (row_pos >= WIN_EDGE && col_pos >= WIN_EDGE) begin
      dr = row_pos - WIN_EDGE;
      dc = col_pos - WIN_EDGE;
      if (dr % step == 0 && dc % step == 0 && dr / step < cfg_oh && dc / step < cfg_ow) begin
        for (i = 0; i < LANES; i++) begin
          acc = lane_merge(col_fold[0][i], col_fold[1][i], now_v[i], cfg_mode);
          // divide by nine, rounding half away from zero
          if (cfg_mode)
            acc = (acc > 0) ? (acc + WINDOW_CELLS / 2) / WINDOW_CELLS
                            : (acc - WINDOW_CELLS / 2) / WINDOW_CELLS;
          res.ch[i] = acc[PIX_W-1:0];
        end
        res.last = (dr / step == cfg_oh - 1) && (dc / step == cfg_ow - 1);
        hit = 1'b1;
      end
    end
    for (i = 0; i < LANES; i++) begin
      col_fold[0][i] = col_fold[1][i];
      col_fold[1][i] = now_v[i];
    end
    upper_line[col]  = middle_line[col];
    middle_line[col] = word;
    col_pos++;
    if (col_pos >= width) begin
      col_pos = 0;
      if (row_pos < ROW_LIMIT) row_pos++;
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout, receiver stall
  // ---------------------------------------------------------------------------
  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted beat against the oldest expectation
  // ---------------------------------------------------------------------------
  quad_t out_quad;
  assign out_quad = {out_result_ch3, out_result_ch2, out_result_ch1, out_result_ch0};

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at result beat %0d: %s", beats_seen, what);
  endtask

  always @(posedge clk) begin
    pooled_t want;
    int      i;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pool.size() == 0) begin
        log_mismatch($sformatf("unexpected beat ch=%h last=%b", out_quad, out_frame_last));
      end else begin
        want = pending_pool.pop_front();
        for (i = 0; i < LANES; i++)
          if (out_quad[i] !== want.ch[i])
            log_mismatch($sformatf("result_ch%0d expected %0d, got %0d", i,
                                   $signed(want.ch[i]), $signed(out_quad[i])));
        if (out_frame_last !== want.last)
          log_mismatch($sformatf("frame_last expected %b, got %b", want.last, out_frame_last));
      end
      beats_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_SEND_LIGHT: begin
        send_gap_pct = 29;
        stall_pct    = 56;
      end
      IDLE_SEND_HEAVY: begin
        send_gap_pct = 56;
        stall_pct    = 29;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
    endcase
  endtask

  // Leaves valid high after the beat; a gap in the next send or a settle lowers it.
  task automatic send_pixel(input quad_t px, input logic pad, input logic fs,
                            input logic typed, input pooled_t typed_res);
    pooled_t pred;
    bit      hit;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_ch0   <= px[0];
    in_pixel_ch1   <= px[1];
    in_pixel_ch2   <= px[2];
    in_pixel_ch3   <= px[3];
    in_is_pad      <= pad;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    hit = pool_step(px, pad, fs, pred);
    if (typed) pending_pool.push_back(typed_res);
    else if (hit) pending_pool.push_back(pred);
  endtask

  // Drop valid, wait for every expected beat, then let the pipe empty.
  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pool.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(input pool3_pkg::reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      pool3_pkg::REG_POOL_MODE:     cfg_mode   = val[0];
      pool3_pkg::REG_WINDOW_STRIDE: cfg_stride = val[1:0];
      pool3_pkg::REG_PADDED_WIDTH:  cfg_pwidth = val[CFG_DIM_W-1:0];
      pool3_pkg::REG_OUT_HEIGHT:    cfg_oh     = val[CFG_DIM_W-1:0];
      pool3_pkg::REG_OUT_WIDTH:     cfg_ow     = val[CFG_DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic mode, input logic [1:0] stride,
                           input logic [CFG_DIM_W-1:0] pw,
                           input logic [CFG_DIM_W-1:0] oh,
                           input logic [CFG_DIM_W-1:0] ow);
    settle(DRAIN_CYCLES);
    cfg_write(pool3_pkg::REG_POOL_MODE,     DATA_W'(mode));
    cfg_write(pool3_pkg::REG_WINDOW_STRIDE, DATA_W'(stride));
    cfg_write(pool3_pkg::REG_PADDED_WIDTH,  DATA_W'(pw));
    cfg_write(pool3_pkg::REG_OUT_HEIGHT,    DATA_W'(oh));
    cfg_write(pool3_pkg::REG_OUT_WIDTH,     DATA_W'(ow));
  endtask

  // One frame of rows x width pixels. Continuation frames carry no frame
  // start, broken ones get stray frame starts, flip frames switch the pool
  // mode at a random pixel while the block sits idle.
  task automatic random_frame(input int rows, input int width, input frame_kind_t kind,
                              input logic border_pad);
    int    n;
    int    k;
    int    r;
    int    c;
    int    i;
    int    pause_at;
    int    flip_at;
    quad_t px;
    logic  pad;
    logic  fs;
    n        = rows * width;
    pause_at = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : -1;
    flip_at  = (kind == FR_MODE_FLIP) ? $urandom_range(n - 1) : -1;
    for (k = 0; k < n; k++) begin
      r = k / width;
      c = k % width;
      if (k == pause_at) settle(0);
      if (k == flip_at) begin
        settle(DRAIN_CYCLES);
        cfg_write(pool3_pkg::REG_POOL_MODE, DATA_W'(!cfg_mode));
      end
      for (i = 0; i < LANES; i++)
        case ($urandom_range(7))
          0:       px[i] = 8'h7F;
          1:       px[i] = 8'h80;
          2:       px[i] = 8'($urandom_range(20)) - 8'd10;   // small values hit rounding
          default: px[i] = 8'($urandom);
        endcase
      pad = border_pad ? (r == 0 || r == rows - 1 || c == 0 || c == width - 1)
                       : ($urandom_range(9) == 0);
      fs  = (k == 0 && kind != FR_CONTINUE) ||
            (kind == FR_BROKEN && k > 0 && $urandom_range(29) == 0);
      send_pixel(px, pad, fs, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  pixel_row_t dir_table [DIR_ROWS];

  initial begin
    int              k;
    int              f;
    int              nframes;
    int              rows;
    int              step;
    int              eff_w;
    int              max_ow;
    int              rand_items;
    logic            mode;
    logic [1:0]      stride;
    logic [CFG_DIM_W-1:0] pw;
    logic [CFG_DIM_W-1:0] oh;
    logic [CFG_DIM_W-1:0] ow;
    frame_kind_t     kind;

    // register defaults and cleared counters, as after reset
    cfg_mode   = 1'b0;
    cfg_stride = 2'd1;
    cfg_pwidth = CFG_DIM_W'(MIN_WIDTH);
    cfg_oh     = CFG_DIM_W'(1);
    cfg_ow     = CFG_DIM_W'(1);
    row_pos    = 0;
    col_pos    = 0;
    col_fold   = '{default: 0};
    foreach (upper_line[j]) begin
      upper_line[j]  = '0;
      middle_line[j] = '0;
    end
    set_idle(IDLE_SEND_LIGHT);
    rand_items = 0;

    // Max frame at reset defaults: all -128 but one pad (its 127 must vanish)
    // and a center pixel of 127/-128/0/-1, which is the only thing that wins.
    for (k = 0; k < WINDOW_CELLS; k++) dir_table[k] = '{32'h80808080, 1'b0, k == 0, 1'b0, '0};
    dir_table[2] = '{32'h7F7F7F7F, 1'b1, 1'b0, 1'b0, '0};
    dir_table[4] = '{32'hFF00807F, 1'b0, 1'b0, 1'b0, '0};
    dir_table[8] = '{32'h80808080, 1'b0, 1'b0, 1'b1, '{32'hFF00807F, 1'b1}};
    // surplus pixel past the frame: no beat
    dir_table[9] = '{32'h7F7F7F7F, 1'b0, 1'b0, 1'b0, '0};
    // Avg frame: all 127, all -128, a lone +5 rounding up, a lone -5 rounding down
    for (k = DIR_MAX_END; k < DIR_ROWS; k++)
      dir_table[k] = '{32'h0000807F, 1'b0, k == DIR_MAX_END, 1'b0, '0};
    dir_table[14] = '{32'hFB05807F, 1'b0, 1'b0, 1'b0, '0};
    dir_table[18] = '{32'h0000807F, 1'b0, 1'b0, 1'b1, '{32'hFF01807F, 1'b1}};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++) begin
      if (k == DIR_MAX_END) begin
        settle(DRAIN_CYCLES);
        cfg_write(pool3_pkg::REG_POOL_MODE, DATA_W'(1'b1));
      end
      send_pixel(dir_table[k].ch, dir_table[k].pad, dir_table[k].fs,
                 dir_table[k].typed, dir_table[k].want);
    end

    // Random settings, a few frames each; idling pattern moves on by thirds.
    while (rand_items < RAND_ITEMS) begin
      if (rand_items < RAND_ITEMS / 3) set_idle(IDLE_SEND_LIGHT);
      else if (rand_items < 2 * RAND_ITEMS / 3) set_idle(IDLE_SEND_HEAVY);
      else set_idle(IDLE_NONE);
      mode = 1'($urandom_range(1));
      case ($urandom_range(9))
        0:       stride = 2'd0;            // codes other than two act as stride one
        1:       stride = 2'd3;
        2, 3, 4: stride = pool3_pkg::STRIDE_TWO;
        default: stride = 2'd1;
      endcase
      step   = (stride == pool3_pkg::STRIDE_TWO) ? 2 : 1;
      pw     = CFG_DIM_W'(($urandom_range(7) == 0) ? $urandom_range(2)
                                                    : $urandom_range(10, 3));
      eff_w  = (pw < MIN_WIDTH) ? MIN_WIDTH : pw;
      max_ow = (eff_w - 3) / step + 1;
      ow     = CFG_DIM_W'(($urandom_range(9) == 0) ? $urandom_range(max_ow + 2)
                                                    : $urandom_range(max_ow, 1));
      oh     = CFG_DIM_W'(($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1));
      configure(mode, stride, pw, oh, ow);
      nframes = $urandom_range(3, 1);
      for (f = 0; f < nframes; f++) begin
        rows = step * (((oh == 0) ? 1 : oh) - 1) + 3 +
               (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
        case ($urandom_range(9))
          0:       kind = (f == 0) ? FR_WHOLE : FR_CONTINUE;
          1:       kind = FR_BROKEN;
          2:       kind = FR_MODE_FLIP;
          default: kind = FR_WHOLE;
        endcase
        random_frame(rows, eff_w, kind, $urandom_range(1));
        rand_items += rows * eff_w;
      end
    end

    // Oversized width clamps to the line store depth: a partial first row, no windows.
    configure(1'b0, 2'd1, 11'd2047, 11'd1, 11'd1024);
    random_frame(1, 96, FR_WHOLE, 1'b0);

    settle(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
